// ===== hw/rtl/hba_pkg.sv =====
// shared types and constants for the heap block allocator
`default_nettype none
package hba_pkg;

  // widths cover the full parameter ranges of the block
  localparam int DATA_W = 25;
  localparam int IDX_W  = 10;
  localparam int OFF_W  = 20;
  localparam int REQ_W  = 21;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOFIT  = 2'd1;
  localparam logic [1:0] STAT_ZERO   = 2'd2;
  localparam logic [1:0] STAT_REJECT = 2'd3;

  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_FIRST = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_REGION = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;

  typedef enum logic [3:0] {
    OP_HOLD,
    OP_INIT,
    OP_SPLIT,
    OP_MARK,
    OP_CLEAR,
    OP_CHK_NEXT,
    OP_CHK_PREV,
    OP_MRG_NEXT,
    OP_MRG_PREV
  } cell_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC,
    ST_CLEAR,
    ST_CHK_NEXT,
    ST_MRG_NEXT,
    ST_CHK_PREV,
    ST_MRG_PREV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] size;
    logic              busy;
  } entry_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] start;
  } carry_t;

  typedef struct packed {
    cell_op_e          op;
    logic              mode;
    logic [1:0]        policy;
    logic [IDX_W-1:0]  pick;
    logic [IDX_W:0]    count;
    logic [DATA_W-1:0] need;
    logic [DATA_W-1:0] rem;
    logic [OFF_W-1:0]  foff;
    logic [DATA_W-1:0] init_size;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hba_cell.sv =====
// one table entry with its slice of the search chain
`default_nettype none
module hba_cell #(
  parameter int IDX          = 0,
  parameter int HEADER_BYTES = 8,
  parameter int RESET_SIZE   = 0
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  hba_pkg::cell_ctrl_t  ctrl_i,
  input  hba_pkg::entry_t      prev_i,
  input  hba_pkg::entry_t      next_i,
  input  hba_pkg::carry_t      carry_i,
  output hba_pkg::entry_t      entry_o,
  output hba_pkg::carry_t      carry_o,
  output logic                 chk_o
);
  import hba_pkg::*;

  localparam logic [IDX_W:0]    ME     = (IDX_W+1)'(IDX);
  localparam logic [IDX_W:0]    ME_P1  = (IDX_W+1)'(IDX + 1);
  localparam logic [DATA_W-1:0] HDR    = DATA_W'(HEADER_BYTES);
  localparam entry_t            RST_ENTRY = '{start: '0, size: DATA_W'(RESET_SIZE),
                                              busy: 1'b0};

  entry_t            entry_q, entry_d;
  carry_t            carry_q, carry_d;
  logic              valid, next_valid, own_ok, take;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] pay;
  logic [IDX_W:0]    pick_x, pick_p1;

  assign pick_x     = {1'b0, ctrl_i.pick};
  assign pick_p1    = pick_x + 1'b1;
  assign valid      = ME < ctrl_i.count;
  assign next_valid = ME_P1 < ctrl_i.count;
  assign rem        = entry_q.size - ctrl_i.need;
  assign pay        = entry_q.start + HDR;

  // fold this entry into the best-so-far record from the left
  always_comb begin
    if (ctrl_i.mode == MODE_ALLOC) begin
      own_ok = valid && !entry_q.busy && (entry_q.size >= ctrl_i.need);
    end else begin
      own_ok = valid && entry_q.busy && (pay[OFF_W-1:0] == ctrl_i.foff);
    end
    take = own_ok && (!carry_i.found ||
           ((ctrl_i.mode == MODE_ALLOC) &&
            (((ctrl_i.policy == POL_BEST) && (rem < carry_i.rem)) ||
             ((ctrl_i.policy == POL_WORST) && (rem > carry_i.rem)))));
    carry_d = carry_i;
    if (take) begin
      carry_d.found = 1'b1;
      carry_d.idx   = ME[IDX_W-1:0];
      carry_d.rem   = rem;
      carry_d.start = entry_q.start;
    end
  end

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      OP_INIT: begin
        entry_d = '0;
        if (ME == '0) begin
          entry_d.size = ctrl_i.init_size;
        end
      end
      OP_SPLIT: begin
        if (ME == pick_x) begin
          entry_d.size = ctrl_i.need;
          entry_d.busy = 1'b1;
        end else if (ME == pick_p1) begin
          entry_d.start = prev_i.start + HDR + ctrl_i.need;
          entry_d.size  = ctrl_i.rem - HDR;
          entry_d.busy  = 1'b0;
        end else if (ME > pick_p1) begin
          entry_d = prev_i;
        end
      end
      OP_MARK: begin
        if (ME == pick_x) begin
          entry_d.busy = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (ME == pick_x) begin
          entry_d.busy = 1'b0;
        end
      end
      OP_MRG_NEXT: begin
        if (ME == pick_x) begin
          entry_d.size = entry_q.size + next_i.size + HDR;
        end else if (ME > pick_x) begin
          entry_d = next_i;
        end
      end
      OP_MRG_PREV: begin
        if (ME_P1 == pick_x) begin
          entry_d.size = entry_q.size + next_i.size + HDR;
        end else if (ME >= pick_x) begin
          entry_d = next_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  // merge probes: only the picked cell or its left neighbor can answer
  assign chk_o = ((ctrl_i.op == OP_CHK_NEXT) && (ME == pick_x) &&
                  next_valid && !next_i.busy) ||
                 ((ctrl_i.op == OP_CHK_PREV) && (ME_P1 == pick_x) &&
                  valid && !entry_q.busy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= RST_ENTRY;
      carry_q <= '0;
    end else begin
      entry_q <= entry_d;
      carry_q <= carry_d;
    end
  end

  assign entry_o = entry_q;
  assign carry_o = carry_q;

endmodule
`default_nettype wire

// ===== hw/rtl/heap_block_allocator_core.sv =====
// heap block allocator top level: sequencer around a chain of table cells
//
//  channel | signals                                         | flow
//  request | start, busy, mode_i, request_bytes_i, free_offset_i | in on start & !busy
//  result  | done_o, payload_offset_o, status_o              | out, one cycle strobe
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i                 | in, write on cfg_we_i
//
// a request scans the cell chain: the best-so-far record moves one cell per clock
// and the last cell is read once it has settled. an allocate then takes ST_ALLOC
// and ST_DONE; a free takes ST_CLEAR, ST_CHK_NEXT, ST_MRG_NEXT if the next block
// is free, ST_CHK_PREV, ST_MRG_PREV if the previous one is free, and ST_DONE. a
// failed search or a zero-size allocate goes straight to ST_DONE. reset leaves one
// free block covering 4096 bytes; a region write reloads the table in the same edge.
// done_o is not held: the receiver cannot stall.
`default_nettype none
module heap_block_allocator_core #(
  parameter int MAX_BLOCKS       = 64,
  parameter int HEADER_BYTES     = 8,
  parameter int REGION_MAX_BYTES = 1048576
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire         mode_i,
  input  wire  [20:0] request_bytes_i,
  input  wire  [19:0] free_offset_i,
  output logic        done_o,
  output logic [19:0] payload_offset_o,
  output logic [1:0]  status_o,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [20:0] cfg_data_i
);
  import hba_pkg::*;

  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int REGION_MIN = 4096;
  localparam logic [DATA_W-1:0] HDR   = DATA_W'(HEADER_BYTES);
  localparam logic [DATA_W-1:0] RMIN  = DATA_W'(REGION_MIN);
  localparam logic [DATA_W-1:0] RMAX  = DATA_W'(REGION_MAX_BYTES);
  localparam logic [DATA_W-1:0] SPLIT_MIN = DATA_W'(HEADER_BYTES + 4);

  state_e              state_q, state_d;
  logic [CW-1:0]       scan_q, scan_d;
  logic [CW-1:0]       count_q, count_d;
  logic [1:0]          policy_q;
  logic                mode_q;
  logic [DATA_W-1:0]   need_q, rem_q;
  logic [OFF_W-1:0]    foff_q;
  logic [IDX_W-1:0]    pick_q;
  logic [OFF_W-1:0]    payload_q;
  logic [1:0]          status_q;
  logic                accept, region_wr, chk, do_split, scan_end;
  logic [REQ_W:0]      need_w;
  logic [DATA_W-1:0]   region_v;
  cell_ctrl_t          ctrl;
  carry_t              last_carry;

  entry_t              entry_w [MAX_BLOCKS];
  carry_t              carry_w [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] chk_vec;

  assign accept    = start && !busy;
  assign region_wr = cfg_we_i && (cfg_idx_i == CFG_REGION);
  assign need_w    = ({1'b0, request_bytes_i} + (REQ_W+1)'(3)) & ~(REQ_W+1)'(3);
  assign chk       = |chk_vec;
  assign last_carry = carry_w[MAX_BLOCKS-1];
  assign do_split  = (rem_q >= SPLIT_MIN) && (count_q < CW'(MAX_BLOCKS));
  // the last cell holds the full result once scan_q reaches MAX_BLOCKS
  assign scan_end  = (state_q == ST_SCAN) && (scan_q == CW'(MAX_BLOCKS));

  // clamp region write into range, word aligned
  always_comb begin
    region_v = DATA_W'(cfg_data_i);
    if (region_v < RMIN) begin
      region_v = RMIN;
    end
    if (region_v > RMAX) begin
      region_v = RMAX;
    end
    region_v = region_v & ~DATA_W'(3);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((mode_i == MODE_ALLOC) && (request_bytes_i == '0)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_q == CW'(MAX_BLOCKS)) begin
          if (!last_carry.found) begin
            state_d = ST_DONE;
          end else if (mode_q == MODE_ALLOC) begin
            state_d = ST_ALLOC;
          end else begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_ALLOC:    state_d = ST_DONE;
      ST_CLEAR:    state_d = ST_CHK_NEXT;
      ST_CHK_NEXT: state_d = chk ? ST_MRG_NEXT : ST_CHK_PREV;
      ST_MRG_NEXT: state_d = ST_CHK_PREV;
      ST_CHK_PREV: state_d = chk ? ST_MRG_PREV : ST_DONE;
      ST_MRG_PREV: state_d = ST_DONE;
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs and cell control
  always_comb begin
    ctrl           = '0;
    ctrl.mode      = mode_q;
    ctrl.policy    = policy_q;
    ctrl.pick      = pick_q;
    ctrl.count     = (IDX_W+1)'(count_q);
    ctrl.need      = need_q;
    ctrl.rem       = rem_q;
    ctrl.foff      = foff_q;
    ctrl.init_size = region_v - HDR;
    ctrl.op        = OP_HOLD;
    count_d        = count_q;
    scan_d         = '0;
    unique case (state_q)
      ST_SCAN:     scan_d = scan_q + 1'b1;
      ST_ALLOC: begin
        if (do_split) begin
          ctrl.op = OP_SPLIT;
          count_d = count_q + 1'b1;
        end else begin
          ctrl.op = OP_MARK;
        end
      end
      ST_CLEAR:    ctrl.op = OP_CLEAR;
      ST_CHK_NEXT: ctrl.op = OP_CHK_NEXT;
      ST_CHK_PREV: ctrl.op = OP_CHK_PREV;
      ST_MRG_NEXT: begin
        ctrl.op = OP_MRG_NEXT;
        count_d = count_q - 1'b1;
      end
      ST_MRG_PREV: begin
        ctrl.op = OP_MRG_PREV;
        count_d = count_q - 1'b1;
      end
      default:     ctrl.op = OP_HOLD;
    endcase
    if (region_wr) begin
      ctrl.op = OP_INIT;
      count_d = CW'(1);
    end
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = (state_q == ST_DONE);
  assign payload_offset_o = payload_q;
  assign status_o         = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      scan_q   <= '0;
      count_q  <= CW'(1);
      policy_q <= POL_BEST;
      status_q <= STAT_OK;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      count_q <= count_d;
      if (cfg_we_i && (cfg_idx_i == CFG_POLICY)) begin
        policy_q <= cfg_data_i[1:0];
      end
      if (accept) begin
        status_q <= STAT_ZERO;
      end
      if (scan_end) begin
        if (!last_carry.found) begin
          status_q <= (mode_q == MODE_ALLOC) ? STAT_NOFIT : STAT_REJECT;
        end else begin
          status_q <= STAT_OK;
        end
      end
    end
  end

  // request and pick registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= mode_i;
      need_q    <= DATA_W'(need_w);
      foff_q    <= free_offset_i;
      payload_q <= '0;
    end
    if (scan_end) begin
      pick_q <= last_carry.idx;
      rem_q  <= last_carry.rem;
      if (last_carry.found && (mode_q == MODE_ALLOC)) begin
        payload_q <= OFF_W'(last_carry.start + HDR);
      end else begin
        payload_q <= '0;
      end
    end
  end

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    entry_t prev_e, next_e;
    carry_t cin;
    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign cin    = '0;
    end else begin : g_mid
      assign prev_e = entry_w[i-1];
      assign cin    = carry_w[i-1];
    end
    if (i == MAX_BLOCKS - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entry_w[i+1];
    end
    hba_cell #(
      .IDX          (i),
      .HEADER_BYTES (HEADER_BYTES),
      .RESET_SIZE   ((i == 0) ? (REGION_MIN - HEADER_BYTES) : 0)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .prev_i  (prev_e),
      .next_i  (next_e),
      .carry_i (cin),
      .entry_o (entry_w[i]),
      .carry_o (carry_w[i]),
      .chk_o   (chk_vec[i])
    );
  end

endmodule
`default_nettype wire

// ===== tb/heap_block_allocator_core_tb.sv =====
// testbench for heap_block_allocator_core: random traffic against a table predictor
`timescale 1ns / 100ps
`default_nettype none

class alloc_scoreboard;
  localparam int NBLK = 64;
  localparam int HDR = 8;

  int unsigned blk_start[NBLK];
  int unsigned blk_size[NBLK];
  bit blk_busy[NBLK];
  int unsigned nblk;
  logic [1:0] policy;
  int unsigned region;
  logic [19:0] exp_off[$];
  logic [1:0] exp_stat[$];
  int errors;
  int mismatches;

  function new();
    errors = 0;
    mismatches = 0;
    policy = hba_pkg::POL_BEST;
    region = 4096;
    init_table();
  endfunction

  function void init_table();
    for (int i = 0; i < NBLK; i++) begin
      blk_start[i] = 0;
      blk_size[i] = 0;
      blk_busy[i] = 0;
    end
    blk_size[0] = region - HDR;
    nblk = 1;
  endfunction

  function void write_cfg(logic idx, logic [20:0] d);
    int unsigned v;
    if (idx == hba_pkg::CFG_POLICY) begin
      policy = d[1:0];
    end else begin
      v = 32'(d);
      if (v < 4096) v = 4096;
      if (v > 1048576) v = 1048576;
      region = v & ~32'd3;
      init_table();
    end
  endfunction

  function void drop_entry(int unsigned idx);
    for (int unsigned i = idx; i + 1 < nblk; i++) begin
      blk_start[i] = blk_start[i+1];
      blk_size[i] = blk_size[i+1];
      blk_busy[i] = blk_busy[i+1];
    end
    nblk--;
  endfunction

  // apply one request to the table and queue the expected answer
  function void note(logic mode, logic [20:0] req, logic [19:0] foff);
    int unsigned need, pick, best_rem, rem, idx;
    logic [19:0] off;
    logic [1:0] st;
    bit found;
    off = '0;
    st = hba_pkg::STAT_OK;
    found = 0;
    pick = 0;
    best_rem = 0;
    if (mode == hba_pkg::MODE_ALLOC) begin
      if (req == 0) begin
        st = hba_pkg::STAT_ZERO;
      end else begin
        need = (32'(req) + 3) & ~32'd3;
        for (int unsigned i = 0; i < nblk; i++) begin
          if (blk_busy[i] || blk_size[i] < need) continue;
          rem = blk_size[i] - need;
          if (!found || (policy == hba_pkg::POL_BEST && rem < best_rem) ||
              (policy == hba_pkg::POL_WORST && rem > best_rem)) begin
            found = 1;
            pick = i;
            best_rem = rem;
          end
          if (policy != hba_pkg::POL_BEST && policy != hba_pkg::POL_WORST) break;
        end
        if (!found) begin
          st = hba_pkg::STAT_NOFIT;
        end else begin
          if (best_rem >= HDR + 4 && nblk < NBLK) begin
            for (int unsigned i = nblk; i > pick + 1; i--) begin
              blk_start[i] = blk_start[i-1];
              blk_size[i] = blk_size[i-1];
              blk_busy[i] = blk_busy[i-1];
            end
            blk_start[pick+1] = blk_start[pick] + HDR + need;
            blk_size[pick+1] = best_rem - HDR;
            blk_busy[pick+1] = 0;
            nblk++;
            blk_size[pick] = need;
          end
          blk_busy[pick] = 1;
          off = 20'(blk_start[pick] + HDR);
        end
      end
    end else begin
      for (int unsigned i = 0; i < nblk; i++) begin
        if (20'(blk_start[i] + HDR) == foff && blk_busy[i]) begin
          found = 1;
          idx = i;
          break;
        end
      end
      if (!found) begin
        st = hba_pkg::STAT_REJECT;
      end else begin
        blk_busy[idx] = 0;
        if (idx + 1 < nblk && !blk_busy[idx+1]) begin
          blk_size[idx] += blk_size[idx+1] + HDR;
          drop_entry(idx + 1);
        end
        if (idx > 0 && !blk_busy[idx-1]) begin
          blk_size[idx-1] += blk_size[idx] + HDR;
          drop_entry(idx);
        end
      end
    end
    exp_off.push_back(off);
    exp_stat.push_back(st);
  endfunction

  function void check(logic [19:0] off, logic [1:0] st);
    logic [19:0] eo;
    logic [1:0] es;
    if (exp_off.size() == 0) begin
      errors++;
      if (mismatches++ < 10) $display("unexpected result: offset %0d status %0d", off, st);
      return;
    end
    eo = exp_off.pop_front();
    es = exp_stat.pop_front();
    if (off !== eo || st !== es) begin
      errors++;
      if (mismatches++ < 10)
        $display("mismatch: offset exp %0d got %0d, status exp %0d got %0d", eo, off, es, st);
    end
  endfunction

  // payload offset of some busy block, or a random offset if none
  function logic [19:0] busy_offset();
    int unsigned cnt, k;
    cnt = 0;
    for (int unsigned i = 0; i < nblk; i++) if (blk_busy[i]) cnt++;
    if (cnt == 0) return 20'($urandom);
    k = $urandom_range(0, cnt - 1);
    for (int unsigned i = 0; i < nblk; i++) begin
      if (blk_busy[i]) begin
        if (k == 0) return 20'(blk_start[i] + HDR);
        k--;
      end
    end
    return '0;
  endfunction
endclass

module heap_block_allocator_core_tb;
  localparam logic MODE_FREE = 1'b1;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic mode = 0;
  logic [20:0] req_bytes = '0;
  logic [19:0] free_off = '0;
  logic done;
  logic [19:0] pay_off;
  logic [1:0] status;
  logic cfg_we = 0;
  logic cfg_idx = 0;
  logic [20:0] cfg_data = '0;
  int n_acc = 0;
  int max_gap = 8;
  alloc_scoreboard sb = new();

  heap_block_allocator_core DUT (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .mode_i(mode), .request_bytes_i(req_bytes), .free_offset_i(free_off),
    .done_o(done), .payload_offset_o(pay_off), .status_o(status),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (done) sb.check(pay_off, status);
      if (start && !busy) begin
        sb.note(mode, req_bytes, free_off);
        n_acc++;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("heap_block_allocator_core_tb: done, errors");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(logic m, logic [20:0] r, logic [19:0] f);
    int target;
    target = n_acc + 1;
    start = 1;
    mode = m;
    req_bytes = r;
    free_off = f;
    wait (n_acc == target);
    @(negedge clk);
    start = 0;
    repeat ($urandom_range(0, max_gap)) @(negedge clk);
  endtask

  task automatic drain();
    while (sb.exp_off.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [20:0] d);
    drain();
    cfg_we = 1;
    cfg_idx = idx;
    cfg_data = d;
    sb.write_cfg(idx, d);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      if ($urandom_range(0, 9) != 0)
        send_request(hba_pkg::MODE_ALLOC, 21'($urandom_range(1, 64)), 20'($urandom));
      else if ($urandom_range(0, 4) != 0)
        send_request(hba_pkg::MODE_ALLOC, 21'($urandom_range(1, sb.region)), 20'($urandom));
      else
        send_request(hba_pkg::MODE_ALLOC, 21'($urandom_range(1, 1048576)), 20'($urandom));
    end else if (r < 92) begin
      send_request(MODE_FREE, 21'($urandom), sb.busy_offset());
    end else if (r < 95) begin
      send_request(hba_pkg::MODE_ALLOC, '0, 20'($urandom));
    end else begin
      send_request(MODE_FREE, 21'($urandom), 20'($urandom));
    end
  endtask

  initial begin
    logic [20:0] regions[6];
    logic [1:0] pols[6];
    logic [19:0] a, b, c;
    regions = '{21'd4096, 21'd1048576, 21'd0, 21'h1FFFFF, 21'd8191, 21'd12288};
    pols = '{hba_pkg::POL_BEST, hba_pkg::POL_FIRST, hba_pkg::POL_WORST, 2'd3,
             hba_pkg::POL_BEST, hba_pkg::POL_FIRST};
    repeat (4) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: edges, bad frees, merges in both directions
    send_request(hba_pkg::MODE_ALLOC, '0, '1);
    send_request(hba_pkg::MODE_ALLOC, 21'd1048576, '0);
    send_request(hba_pkg::MODE_ALLOC, 21'd4088, '0);
    send_request(MODE_FREE, '0, 20'd8);
    send_request(MODE_FREE, '1, 20'hFFFFF);
    send_request(hba_pkg::MODE_ALLOC, 21'd1, '0);
    a = sb.exp_off.size() ? 20'd8 : 20'd8;
    send_request(hba_pkg::MODE_ALLOC, 21'd5, '0);
    send_request(hba_pkg::MODE_ALLOC, 21'd3000, '0);
    send_request(hba_pkg::MODE_ALLOC, 21'd1000, '0);
    b = 20'd20;
    c = 20'd36;
    send_request(MODE_FREE, '0, a);
    send_request(MODE_FREE, '0, c);
    send_request(MODE_FREE, '0, b);
    send_request(MODE_FREE, '0, b);
    send_request(hba_pkg::MODE_ALLOC, 21'd4080, '0);
    send_request(hba_pkg::MODE_ALLOC, 21'd4, '0);
    write_reg(hba_pkg::CFG_REGION, 21'd4096);

    for (int ph = 0; ph < 12; ph++) begin
      write_reg(hba_pkg::CFG_POLICY, {19'($urandom), pols[ph % 6]});
      if (ph % 2 == 0) write_reg(hba_pkg::CFG_REGION, regions[(ph / 2) % 6]);
      max_gap = (ph % 4 == 3) ? 0 : 8;
      for (int i = 0; i < 70; i++) begin
        random_request();
        if (ph == 5 && i == 30) drain();
      end
    end
    write_reg(hba_pkg::CFG_REGION, 21'($urandom));

    drain();
    if (sb.errors == 0) begin
      $display("heap_block_allocator_core_tb: done, clean");
    end else begin
      $display("heap_block_allocator_core_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
